// File: hw/rtl/rpvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Random page victim table package
// Shared sizes, codes and types for the random page replacement table.
// ----------------------------------------------------------------------------
package rpvt_pkg;

    localparam int CAPACITY    = 64;
    localparam int PAGE_BITS   = 20;
    localparam int DRAW_W      = 16;
    localparam int MAX_RES_W   = 7;
    localparam int RES_CNT_W   = 7;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int STEP_W      = $clog2(DRAW_W + 1);

    localparam int S_TDATA_W   = ((PAGE_BITS + DRAW_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((PAGE_BITS + RES_CNT_W + 7) / 8) * 8;

    localparam logic [MAX_RES_W-1:0] PAGE_LIMIT_RST = MAX_RES_W'(64);

    typedef enum logic {
        OP_MAP   = 1'b0,
        OP_EVICT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_MAPPED  = 2'd0,
        ST_EVICTED = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // Request to and answer from the modulo unit.
    typedef struct packed {
        logic              start;
        logic [DRAW_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] remainder;
    } mod_rsp_t;

endpackage
`default_nettype wire

// File: hw/rtl/rpvt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rpvt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 20
) (
    input  wire logic                                      aclk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/rpvt_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative modulo unit
// Restoring division, one dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module rpvt_mod (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rpvt_pkg::mod_req_t req,
    output rpvt_pkg::mod_rsp_t     rsp
);
    import rpvt_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DRAW_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W:0]    trial;

    // Shift the next dividend bit into the partial remainder and subtract
    // the divisor whenever it fits.
    assign trial = {rem_reg, quo_reg[DRAW_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(DRAW_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DRAW_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = CNT_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[CNT_W-1:0];
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule
`default_nettype wire

// File: hw/rtl/random_page_victim_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Random page victim table
// Compact table of resident pages; maps append, evictions pick a random slot.
// ----------------------------------------------------------------------------
// Flow: map, full and empty requests go from acceptance straight to the result
// stage; an eviction first runs the bit-serial modulo of the draw by the count,
// takes the remainder as the slot, then does the two reads and the write-back
// on the one RAM. One request is in flight at a time; the next is taken once
// the result is in the output register. Reset clears the count, sets the limit
// to 64 and leaves the page RAM undefined.
module random_page_victim_table_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration: resident page limit.
    input  wire logic                             cfg_we,
    input  wire logic [rpvt_pkg::MAX_RES_W-1:0]   cfg_wdata,
    // Request channel.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata: page_number [19:0], random_draw [35:20], zero fill above.
    input  wire logic [rpvt_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: operation.
    input  wire logic                             s_tuser,
    // Result channel.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata: victim_page [19:0], resident_count [26:20], zero fill above.
    output logic [rpvt_pkg::M_TDATA_W-1:0]        m_tdata,
    // m_tuser: status.
    output logic [1:0]                            m_tuser
);
    import rpvt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DIVIDE    = 6'b000010,
        S_RD_VICTIM = 6'b000100,
        S_RD_LAST   = 6'b001000,
        S_WRITE     = 6'b010000,
        S_RESULT    = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [MAX_RES_W-1:0]   max_res_reg, max_res_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic [PAGE_BITS-1:0]   victim_reg, victim_next;
    status_t                status_reg, status_next;

    logic                   out_valid_reg, out_valid_next;
    logic [PAGE_BITS-1:0]   out_victim_reg, out_victim_next;
    status_t                out_status_reg, out_status_next;
    logic [RES_CNT_W-1:0]   out_count_reg, out_count_next;

    logic                   accept;
    op_t                    in_op;
    logic [PAGE_BITS-1:0]   in_page;
    logic [DRAW_W-1:0]      in_draw;
    logic                   table_full;
    logic                   out_free;
    logic [IDX_W-1:0]       last_idx;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [PAGE_BITS-1:0]   ram_wdata;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [PAGE_BITS-1:0]   ram_rdata;

    mod_req_t               mod_req;
    mod_rsp_t               mod_rsp;

    assign in_op    = op_t'(s_tuser);
    assign in_page  = s_tdata[PAGE_BITS-1:0];
    assign in_draw  = s_tdata[PAGE_BITS +: DRAW_W];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    // The limit is the register clamped to the table size.
    assign table_full = (32'(count_reg) >= 32'(max_res_reg)) ||
                        (32'(count_reg) >= 32'(CAPACITY));

    always_comb begin
        state_next   = state_reg;
        max_res_next = cfg_we ? cfg_wdata : max_res_reg;
        count_next   = count_reg;
        slot_next    = slot_reg;
        victim_next  = victim_reg;
        status_next  = status_reg;

        ram_we    = 1'b0;
        ram_waddr = count_reg[IDX_W-1:0];
        ram_wdata = in_page;
        ram_re    = 1'b0;
        ram_raddr = slot_reg;

        mod_req.start    = 1'b0;
        mod_req.dividend = in_draw;
        mod_req.divisor  = count_reg;

        out_valid_next  = out_valid_reg && !m_tready;
        out_victim_next = out_victim_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    victim_next = '0;
                    state_next  = S_RESULT;
                    if (in_op == OP_MAP) begin
                        if (table_full) begin
                            status_next = ST_FULL;
                        end else begin
                            ram_we      = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = ST_MAPPED;
                        end
                    end else if (count_reg == '0) begin
                        status_next = ST_EMPTY;
                    end else begin
                        mod_req.start = 1'b1;
                        status_next   = ST_EVICTED;
                        state_next    = S_DIVIDE;
                    end
                end
            end
            S_DIVIDE: begin
                if (mod_rsp.done) begin
                    slot_next  = mod_rsp.remainder[IDX_W-1:0];
                    state_next = S_RD_VICTIM;
                end
            end
            S_RD_VICTIM: begin
                ram_re     = 1'b1;
                ram_raddr  = slot_reg;
                state_next = S_RD_LAST;
            end
            S_RD_LAST: begin
                victim_next = ram_rdata;
                ram_re      = 1'b1;
                ram_raddr   = last_idx;
                state_next  = S_WRITE;
            end
            S_WRITE: begin
                // The last entry fills the hole; harmless when the slot is last.
                ram_we     = 1'b1;
                ram_waddr  = slot_reg;
                ram_wdata  = ram_rdata;
                count_next = count_reg - CNT_W'(1);
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_victim_next = victim_reg;
                    out_status_next = status_reg;
                    out_count_next  = RES_CNT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            max_res_reg   <= PAGE_LIMIT_RST;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            max_res_reg   <= max_res_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg       <= slot_next;
        victim_reg     <= victim_next;
        status_reg     <= status_next;
        out_victim_reg <= out_victim_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    rpvt_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    rpvt_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (PAGE_BITS)
    ) u_pages (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = M_TDATA_W'({out_count_reg, out_victim_reg});

endmodule
`default_nettype wire

// File: tb/sv/rpvt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random page victim table checker
// Watches the configuration port and both stream channels, keeps a shadow copy
// of the page table, predicts the answer to every accepted request and
// compares each returned answer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rpvt_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [rpvt_pkg::MAX_RES_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [rpvt_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [rpvt_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [1:0]                       m_tuser,
    output int unsigned                      outstanding,
    output int unsigned                      error_count
);

    typedef struct packed {
        logic [rpvt_pkg::PAGE_BITS-1:0] victim;
        rpvt_pkg::status_t              status;
        logic [rpvt_pkg::RES_CNT_W-1:0] count;
    } table_answer_t;

    logic [rpvt_pkg::PAGE_BITS-1:0] shadow_pages [rpvt_pkg::CAPACITY];
    logic [rpvt_pkg::RES_CNT_W-1:0] shadow_count;
    logic [rpvt_pkg::MAX_RES_W-1:0] shadow_limit;
    table_answer_t                  pending_answers [$];

    initial begin
        outstanding = 0;
        error_count = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Applies one request to the shadow table and returns the answer it earns.
    function automatic table_answer_t apply_request(input rpvt_pkg::op_t op,
                                                    input logic [rpvt_pkg::PAGE_BITS-1:0] page,
                                                    input logic [rpvt_pkg::DRAW_W-1:0] draw);
        table_answer_t ans;
        int unsigned   room;
        int unsigned   slot;
        ans.victim = '0;
        room = (int'(shadow_limit) < rpvt_pkg::CAPACITY) ? shadow_limit : rpvt_pkg::CAPACITY;
        if (op == rpvt_pkg::OP_MAP) begin
            if (shadow_count >= room) begin
                ans.status = rpvt_pkg::ST_FULL;
            end else begin
                shadow_pages[shadow_count] = page;
                shadow_count = shadow_count + 1'b1;
                ans.status = rpvt_pkg::ST_MAPPED;
            end
        end else if (shadow_count == 0) begin
            ans.status = rpvt_pkg::ST_EMPTY;
        end else begin
            slot = int'(draw) % int'(shadow_count);
            ans.victim = shadow_pages[slot];
            shadow_count = shadow_count - 1'b1;
            // The last resident entry fills the hole left by the victim.
            shadow_pages[slot] = shadow_pages[shadow_count];
            ans.status = rpvt_pkg::ST_EVICTED;
        end
        ans.count = shadow_count;
        return ans;
    endfunction

    always @(posedge aclk) begin
        table_answer_t want;
        if (!aresetn) begin
            shadow_count = '0;
            shadow_limit = rpvt_pkg::PAGE_LIMIT_RST;
            pending_answers.delete();
        end else begin
            if (cfg_we) begin
                shadow_limit = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                pending_answers.push_back(apply_request(
                    rpvt_pkg::op_t'(s_tuser),
                    s_tdata[rpvt_pkg::PAGE_BITS-1:0],
                    s_tdata[rpvt_pkg::PAGE_BITS +: rpvt_pkg::DRAW_W]));
            end
            if (m_tvalid && m_tready) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch("answer with no request waiting", m_tdata, '0);
                end else begin
                    want = pending_answers.pop_front();
                    if (m_tdata[rpvt_pkg::PAGE_BITS-1:0] !== want.victim) begin
                        report_mismatch("victim_page", m_tdata[rpvt_pkg::PAGE_BITS-1:0],
                                        want.victim);
                    end
                    if (m_tuser !== want.status) begin
                        report_mismatch("status", m_tuser, want.status);
                    end
                    if (m_tdata[rpvt_pkg::PAGE_BITS +: rpvt_pkg::RES_CNT_W] !== want.count) begin
                        report_mismatch("resident_count",
                                        m_tdata[rpvt_pkg::PAGE_BITS +: rpvt_pkg::RES_CNT_W],
                                        want.count);
                    end
                end
            end
        end
        outstanding <= pending_answers.size();
    end

endmodule

// File: tb/sv/random_page_victim_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random page victim table testbench
// Drives map and evict requests under several table limits and idling mixes;
// the checker beside the block predicts and compares every answer.
// ----------------------------------------------------------------------------
module random_page_victim_table_unit_tb;

    import rpvt_pkg::*;

    localparam int ITEMS_PER_PHASE = 67;
    localparam int NUM_PHASES      = 6;
    localparam int CYCLE_LIMIT     = 400000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [MAX_RES_W-1:0]  cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;

    int unsigned outstanding;
    int unsigned error_count;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycle_count   = 0;

    // Limits for the random phases, the extremes among them.
    logic [MAX_RES_W-1:0] phase_limits [NUM_PHASES] = '{7'd64, 7'd127, 7'd7, 7'd1, 7'd0, 7'd40};

    always #6 aclk = ~aclk;

    random_page_victim_table_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    rpvt_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .outstanding (outstanding),
        .error_count (error_count)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_request(input op_t op, input logic [PAGE_BITS-1:0] page,
                                input logic [DRAW_W-1:0] draw);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({draw, page});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Holds the request channel quiet until every answer has come back.
    task automatic drain_answers();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [MAX_RES_W-1:0] value);
        drain_answers();
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [DRAW_W-1:0] pick_draw();
        case ($urandom_range(7))
            0: pick_draw = '0;
            1: pick_draw = '1;
            default: pick_draw = DRAW_W'($urandom_range(65535));
        endcase
    endfunction

    initial begin
        int unsigned map_pct;
        op_t         op;

        send_idle_pct <= 9;
        recv_idle_pct <= 72;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, starting at the reset limit of 64.
        send_request(OP_EVICT, 20'h00000, 16'h0000);
        send_request(OP_MAP, 20'h00000, 16'hFFFF);
        send_request(OP_MAP, 20'hFFFFF, 16'h0000);
        send_request(OP_MAP, 20'hA5A5A, 16'h1234);
        send_request(OP_EVICT, 20'h12345, 16'hFFFF);
        send_request(OP_EVICT, 20'hFFFFF, 16'h0000);

        // Lowest usable limit: one map fits, the next is refused.
        set_limit(7'd1);
        send_request(OP_MAP, 20'h11111, 16'h0000);
        send_request(OP_EVICT, 20'h00000, 16'h8000);
        send_request(OP_EVICT, 20'h00000, 16'h7FFF);
        send_request(OP_MAP, 20'h5A5A5, 16'h0000);
        send_request(OP_MAP, 20'h0F0F0, 16'h0000);

        // A zero limit refuses every map but still lets evictions through.
        set_limit(7'd0);
        send_request(OP_MAP, 20'h33333, 16'h0000);
        send_request(OP_EVICT, 20'h00000, 16'h0001);
        send_request(OP_MAP, 20'h44444, 16'h0000);

        // Largest register value is clamped to the table capacity.
        set_limit(7'd127);
        send_request(OP_MAP, 20'h80000, 16'h0000);
        send_request(OP_MAP, 20'h00001, 16'h0000);
        send_request(OP_MAP, 20'h7FFFE, 16'h0000);
        send_request(OP_MAP, 20'hC3C3C, 16'h0000);

        // Limit dropped below the count: residents stay, maps are refused until evictions bring the count under it.
        set_limit(7'd2);
        send_request(OP_MAP, 20'h55555, 16'h0000);
        send_request(OP_EVICT, 20'h00000, 16'h0003);
        send_request(OP_EVICT, 20'h00000, 16'hFFFE);
        send_request(OP_MAP, 20'h66666, 16'h0000);
        send_request(OP_EVICT, 20'h00000, 16'h0002);
        send_request(OP_MAP, 20'h77777, 16'h0000);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            set_limit(phase_limits[phase]);
            case (phase / 2)
                0: begin
                    send_idle_pct <= 9;
                    recv_idle_pct <= 72;
                end
                1: begin
                    send_idle_pct <= 72;
                    recv_idle_pct <= 9;
                end
                default: begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // Mostly maps early in a phase to fill the table, then mostly evictions.
                map_pct = (i < 45) ? 92 : 15;
                op = ($urandom_range(99) < map_pct) ? OP_MAP : OP_EVICT;
                send_request(op, PAGE_BITS'($urandom), pick_draw());
                if (i == ITEMS_PER_PHASE / 2) begin
                    drain_answers();
                end
            end
        end

        drain_answers();
        repeat (30) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
